@@ hw/rtl/hpt_pkg.sv @@
// Package for the homogeneous point transform core: request and result types,
// operation codes and controller state, command and status types. No dependencies.
package hpt_pkg;

    typedef enum logic [2:0] {
        FUNC_WR_CUR   = 3'd0,
        FUNC_WR_STG   = 3'd1,
        FUNC_COMPOSE  = 3'd2,
        FUNC_IDENTITY = 3'd3,
        FUNC_XFORM    = 3'd4
    } func_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_zero;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_IDENT,
        ST_CMP_MAC,
        ST_CMP_COPY,
        ST_XF_MAC,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic do_write;
        logic do_ident;
        logic mac_clear;
        logic mac_step;
        logic cmp_store;
        logic cmp_copy;
        logic xf_store;
        logic div_start;
        logic div_step;
        logic res_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mac_last;
        logic cell_last;
        logic div_last;
        logic div_lane_last;
    } dp_sts_t;

endpackage

@@ hw/rtl/hpt_datapath.sv @@
// Datapath of the point transform core: matrices, multiply-accumulate unit
// and shared restoring divider. Depends on hpt_pkg.
module hpt_datapath
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  req_t    req,
    input  dp_cmd_t cmd,
    output dp_sts_t sts,
    output res_t    res
);
    localparam int VW    = VALUE_WIDTH;
    localparam int OW    = (VW < 32) ? VW : 32;
    localparam int PW    = 2 * VW;
    localparam int AW    = PW + 3;
    localparam int NW    = VW + FRAC_BITS;
    localparam int QW    = NW;
    localparam int DCW   = $clog2(NW + 1);
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [NW:0] ONE_W = {{(NW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [VW-1:0] ONE_V =
        (FRAC_BITS >= VW - 1) ? VMAX : VW'(ONE_W);
    localparam logic [QW-1:0] OMAX = QW'({1'b0, {(OW-1){1'b1}}});

    // Saturate a 32-bit input into the value width.
    function automatic logic signed [VW-1:0] sat_in(input logic signed [31:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > 64'(VMAX))      sat_in = VMAX;
        else if (e < 64'(VMIN)) sat_in = VMIN;
        else                    sat_in = VW'(e);
    endfunction

    logic signed [VW-1:0] cur_reg [16];
    logic signed [VW-1:0] stg_reg [16];
    logic signed [VW-1:0] nxt_reg [16];
    req_t                 req_reg;
    logic [1:0]           k_reg;
    logic [3:0]           cell_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 prod_vld_reg;
    logic signed [VW-1:0] r_reg [4];
    logic [1:0]           lane_reg;
    logic [NW-1:0]        num_reg;
    logic [VW:0]          den_reg;
    logic [VW:0]          rem_reg;
    logic [QW-1:0]        quo_reg;
    logic                 neg_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic signed [OW-1:0] q_reg [2];
    res_t                 res_reg;

    // Operand selection for the multiplier.
    logic signed [VW-1:0] opa, opb;
    logic [1:0] row, col;
    logic signed [VW-1:0] pnt;
    assign row = cell_reg[3:2];
    assign col = cell_reg[1:0];
    always_comb begin
        unique case (k_reg)
            2'd0:    pnt = sat_in(req_reg.point_x);
            2'd1:    pnt = sat_in(req_reg.point_y);
            default: pnt = sat_in(req_reg.point_z);
        endcase
        if (req_reg.func == FUNC_COMPOSE) begin
            opa = stg_reg[{row, k_reg}];
            opb = cur_reg[{k_reg, col}];
        end else begin
            opa = pnt;
            opb = cur_reg[{row, k_reg}];
        end
    end

    // Floor shift and saturation of the accumulator.
    logic signed [AW-1:0] acc_fin, shifted;
    logic signed [VW-1:0] resc;
    assign acc_fin = acc_reg + (prod_vld_reg ? AW'(prod_reg) : '0);
    assign shifted = acc_fin >>> FRAC_BITS;
    always_comb begin
        if (shifted > AW'(VMAX))      resc = VMAX;
        else if (shifted < AW'(VMIN)) resc = VMIN;
        else                          resc = VW'(shifted);
    end

    // Divider operands for the current lane.
    logic signed [VW-1:0] lnum, lden;
    logic [VW-1:0] mnum;
    logic [VW:0]   mden;
    assign lnum = r_reg[lane_reg];
    assign lden = r_reg[3];
    assign mnum = lnum[VW-1] ? VW'(-lnum) : VW'(lnum);
    assign mden = lden[VW-1] ? -{lden[VW-1], lden} : {1'b0, lden};

    logic [VW+1:0] rem_sh;
    logic [VW+1:0] rem_sub;
    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    logic [QW-1:0] qlim;
    logic [QW-1:0] qsat;
    logic signed [OW-1:0] qfin;
    assign qlim = neg_reg ? OMAX + QW'(1) : OMAX;
    assign qsat = (quo_reg > qlim) ? qlim : quo_reg;
    assign qfin = neg_reg ? -OW'(qsat) : OW'(qsat);

    // A compose entry ends after four products, a transform row after three.
    assign sts.mac_last      = (req_reg.func == FUNC_COMPOSE) ?
                               (k_reg == 2'd0 && prod_vld_reg) : (k_reg == 2'd3);
    assign sts.cell_last     = (req_reg.func == FUNC_COMPOSE) ? (cell_reg == 4'd15)
                                                              : (row == 2'd3);
    assign sts.div_last      = (dcnt_reg == DCW'(NW - 1));
    assign sts.div_lane_last = (lane_reg == 2'd2);
    assign res = res_reg;

    // Matrix state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                cur_reg[i] <= (i % 5 == 0) ? ONE_V : '0;
                stg_reg[i] <= '0;
            end
        end else if (cmd.do_write) begin
            if (req_reg.func == FUNC_WR_CUR)
                cur_reg[req_reg.entry_index] <= sat_in(req_reg.entry_value);
            else
                stg_reg[req_reg.entry_index] <= sat_in(req_reg.entry_value);
        end else if (cmd.do_ident) begin
            for (int i = 0; i < 16; i++) cur_reg[i] <= (i % 5 == 0) ? ONE_V : '0;
        end else if (cmd.cmp_copy) begin
            for (int i = 0; i < 16; i++) cur_reg[i] <= nxt_reg[i];
        end
    end

    // Sequencing of the multiply-accumulate unit and the divider.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) req_reg <= req;
        if (cmd.mac_clear) begin
            k_reg        <= '0;
            cell_reg     <= '0;
            prod_vld_reg <= 1'b0;
            lane_reg     <= '0;
            // A transform row starts from its translation term.
            acc_reg      <= (req.func == FUNC_XFORM) ? (AW'(cur_reg[3]) <<< FRAC_BITS)
                                                     : '0;
        end
        if (cmd.mac_step) begin
            prod_reg     <= PW'(opa) * PW'(opb);
            prod_vld_reg <= 1'b1;
            acc_reg      <= acc_fin;
            k_reg        <= k_reg + 2'd1;
        end
        if (cmd.cmp_store || cmd.xf_store) begin
            // The next entry or row starts with an empty product pipeline.
            prod_vld_reg <= 1'b0;
            k_reg        <= '0;
            cell_reg     <= (req_reg.func == FUNC_COMPOSE) ? cell_reg + 4'd1
                                                           : cell_reg + 4'd4;
            if (req_reg.func == FUNC_COMPOSE) begin
                nxt_reg[cell_reg] <= resc;
                acc_reg           <= '0;
            end else begin
                r_reg[row]        <= resc;
                acc_reg           <= AW'(cur_reg[{row + 2'd1, 2'd3}]) <<< FRAC_BITS;
            end
        end
        if (cmd.div_start) begin
            num_reg  <= {mnum, {FRAC_BITS{1'b0}}};
            den_reg  <= mden;
            rem_reg  <= '0;
            quo_reg  <= '0;
            neg_reg  <= lnum[VW-1] ^ lden[VW-1];
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            num_reg  <= num_reg << 1;
            dcnt_reg <= dcnt_reg + DCW'(1);
            if (!rem_sub[VW+1]) begin
                rem_reg <= rem_sub[VW:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[VW:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.div_step && sts.div_last) begin
            lane_reg <= lane_reg + 2'd1;
        end
        // The quotient of the previous lane is kept when the next one starts.
        if (cmd.div_start && lane_reg != 2'd0) q_reg[1'(lane_reg - 2'd1)] <= qfin;
        if (cmd.res_load) begin
            if (r_reg[3] == '0) begin
                res_reg <= '{out_x: '0, out_y: '0, out_z: '0, w_zero: 1'b1};
            end else begin
                res_reg.out_x  <= 32'(q_reg[0]);
                res_reg.out_y  <= 32'(q_reg[1]);
                res_reg.out_z  <= 32'(qfin);
                res_reg.w_zero <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/hpt_ctrl.sv @@
// Controller state machine of the point transform core. Sequences the
// datapath through commands and owns the handshakes. Depends on hpt_pkg.
module hpt_ctrl
    import hpt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic [2:0] s_func,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   res_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    // The result register can take a new result once the old one is gone.
    assign res_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_WR_CUR, FUNC_WR_STG: state_next = ST_WRITE;
                        FUNC_COMPOSE:             state_next = ST_CMP_MAC;
                        FUNC_IDENTITY:            state_next = ST_IDENT;
                        FUNC_XFORM:               state_next = ST_XF_MAC;
                        default:                  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE, ST_IDENT, ST_CMP_COPY: state_next = ST_IDLE;
            ST_CMP_MAC:
                if (sts.mac_last && sts.cell_last) state_next = ST_CMP_COPY;
            ST_XF_MAC:
                if (sts.mac_last && sts.cell_last) state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_RUN;
            ST_DIV_RUN:
                if (sts.div_last)
                    state_next = sts.div_lane_last ? ST_RESULT : ST_DIV_START;
            ST_RESULT:
                if (res_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_req  = accept;
                cmd.mac_clear = accept;
            end
            ST_WRITE: cmd.do_write = 1'b1;
            ST_IDENT: cmd.do_ident = 1'b1;
            ST_CMP_COPY: cmd.cmp_copy = 1'b1;
            ST_CMP_MAC: begin
                cmd.mac_step  = !sts.mac_last;
                cmd.cmp_store = sts.mac_last;
            end
            ST_XF_MAC: begin
                cmd.mac_step = !sts.mac_last;
                cmd.xf_store = sts.mac_last;
            end
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_RUN:   cmd.div_step  = 1'b1;
            ST_RESULT: begin
                if (res_free) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |=> m_valid) else $error("result not raised");
    a_div_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_START) |=> (state_reg == ST_DIV_RUN))
        else $error("divider sequence broken");
`endif

endmodule

@@ hw/rtl/homogeneous_point_transform_core.sv @@
// Homogeneous 4x4 point transform core with perspective divide.
// Request channel s_*: valid/ready, payload s_data (req_t). Result channel
// m_*: valid/ready, payload m_data (res_t); only transform requests give one.
// Matrix writes and identity pass through ST_WRITE or ST_IDENT once accepted.
// Compose works through 16 entries, each in four multiply steps and a store,
// then copies the result into the current matrix. A transform works through
// the four rows, each in multiply steps over x, y and z and a store, then runs
// three bit-serial divides, each a start step and one step per quotient bit;
// ST_RESULT then loads the result and raises m_valid, and the core goes idle.
// One request is in work at a time. A new request is taken while a result
// still waits; a following transform holds in its last step until the
// receiver has taken the earlier result.
// Reset (aresetn low, synchronous) sets the current matrix to identity,
// clears the staging matrix and drops m_valid.
// A stalled receiver holds m_valid and m_data steady until m_ready.
// Depends on hpt_pkg, hpt_ctrl and hpt_datapath.
module homogeneous_point_transform_core
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);
    dp_cmd_t cmd;
    dp_sts_t sts;

    hpt_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func(s_data.func),
        .m_valid, .m_ready, .cmd, .sts
    );

    hpt_datapath #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk, .aresetn, .req(s_data), .cmd, .sts, .res(m_data)
    );

endmodule

@@ test/homogeneous_point_transform_core_tb.sv @@
// Testbench for homogeneous_point_transform_core: drives matrix write, compose,
// identity, transform and unused-selector requests and checks every result against a predictor.
// Depends on hpt_pkg and the core RTL.
`timescale 1ns / 1ps

module homogeneous_point_transform_core_tb;
    import hpt_pkg::*;

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;

    homogeneous_point_transform_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Predictor state.
    logic signed [31:0] cur_mtx [16];
    logic signed [31:0] stg_mtx [16];
    res_t pending_points [$];
    int errors = 0;
    bit idle_on = 1'b1;

    // Floor shift by FRAC bits, saturate to 32 bits.
    function automatic logic signed [31:0] rescale(input logic signed [127:0] s);
        logic signed [127:0] r;
        r = s >>> FRAC;
        if (r > 128'sd2147483647) return MAXV;
        if (r < -128'sd2147483648) return MINV;
        return r[31:0];
    endfunction

    // Truncated (num << FRAC) / den, saturated to 32 bits.
    function automatic logic signed [31:0] fx_quot(input logic signed [31:0] num,
                                                   input logic signed [31:0] den);
        logic signed [127:0] q;
        q = (128'(num) <<< FRAC) / 128'(den);
        if (q > 128'sd2147483647) return MAXV;
        if (q < -128'sd2147483648) return MINV;
        return q[31:0];
    endfunction

    task automatic load_identity();
        for (int i = 0; i < 16; i++) cur_mtx[i] = (i % 5 == 0) ? ONE_Q : 32'sd0;
    endtask

    // Apply one request to the predictor; queue a result for transforms.
    task automatic predict_request(input req_t rq);
        logic signed [31:0] nxt [16];
        logic signed [31:0] pt [3];
        logic signed [31:0] hv [4];
        logic signed [127:0] acc;
        res_t rs;
        case (rq.func)
            FUNC_WR_CUR: cur_mtx[rq.entry_index] = rq.entry_value;
            FUNC_WR_STG: stg_mtx[rq.entry_index] = rq.entry_value;
            FUNC_COMPOSE: begin
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += 128'(stg_mtx[i*4+k]) * 128'(cur_mtx[k*4+j]);
                        nxt[i*4+j] = rescale(acc);
                    end
                for (int i = 0; i < 16; i++) cur_mtx[i] = nxt[i];
            end
            FUNC_IDENTITY: load_identity();
            FUNC_XFORM: begin
                pt[0] = rq.point_x; pt[1] = rq.point_y; pt[2] = rq.point_z;
                for (int i = 0; i < 4; i++) begin
                    acc = 128'(cur_mtx[i*4+3]) <<< FRAC;
                    for (int k = 0; k < 3; k++) acc += 128'(pt[k]) * 128'(cur_mtx[i*4+k]);
                    hv[i] = rescale(acc);
                end
                if (hv[3] == 0) begin
                    rs = '{out_x: 0, out_y: 0, out_z: 0, w_zero: 1'b1};
                end else begin
                    rs = '{out_x: fx_quot(hv[0], hv[3]), out_y: fx_quot(hv[1], hv[3]),
                           out_z: fx_quot(hv[2], hv[3]), w_zero: 1'b0};
                end
                pending_points.push_back(rs);
            end
            default: ;
        endcase
    endtask

    function automatic req_t make_req(input logic [2:0] f, input logic [3:0] idx,
                                      input logic [31:0] v, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z);
        req_t r;
        r.func = f; r.entry_index = idx; r.entry_value = v;
        r.point_x = x; r.point_y = y; r.point_z = z;
        return r;
    endfunction

    // Send one request: optional idle burst, then hold valid until accepted.
    task automatic send_request(input req_t rq);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_data <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_request(rq);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return MAXV;
            2: return MINV;
            default: return $signed($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return ($urandom_range(0, 1)) ? MAXV : MINV;
            2: return 32'sd0;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // Receiver: random stall bursts, checks each result in order.
    initial begin
        res_t want;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_points.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    want = pending_points.pop_front();
                    if (m_data.out_x !== want.out_x)
                        $display("%0t: out_x expected %h actual %h", $time, want.out_x, m_data.out_x);
                    if (m_data.out_y !== want.out_y)
                        $display("%0t: out_y expected %h actual %h", $time, want.out_y, m_data.out_y);
                    if (m_data.out_z !== want.out_z)
                        $display("%0t: out_z expected %h actual %h", $time, want.out_z, m_data.out_z);
                    if (m_data.w_zero !== want.w_zero)
                        $display("%0t: w_zero expected %b actual %b", $time, want.w_zero, m_data.w_zero);
                    if (m_data !== want) errors++;
                end
            end
        end
    end

    // Directed table: request plus an optional typed-in expected result.
    typedef struct {
        req_t req;
        bit   has_exp;
        res_t expv;
    } dir_row_t;

    initial begin
        dir_row_t rows [$];
        req_t rq;
        logic [3:0] idx;
        load_identity();
        for (int i = 0; i < 16; i++) stg_mtx[i] = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Identity after reset: a point comes back unchanged.
        rows.push_back('{make_req(FUNC_XFORM, 0, 0, ONE_Q, -ONE_Q, 32'sh0002_8000), 1,
                         '{ONE_Q, -ONE_Q, 32'sh0002_8000, 1'b0}});
        rows.push_back('{make_req(FUNC_XFORM, 4'hf, MAXV, MAXV, MINV, 0), 1,
                         '{MAXV, MINV, 0, 1'b0}});
        // Zero w: clear the bottom-right entry.
        rows.push_back('{make_req(FUNC_WR_CUR, 15, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_XFORM, 0, 0, ONE_Q, ONE_Q, ONE_Q), 1,
                         '{0, 0, 0, 1'b1}});
        // Tiny w: quotients saturate to both limits.
        rows.push_back('{make_req(FUNC_WR_CUR, 15, 1, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_XFORM, 0, 0, MAXV, MINV, 0), 0, '0});
        // Unused selectors change nothing.
        rows.push_back('{make_req(3'd5, 15, MAXV, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(3'd6, 0, MINV, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(3'd7, 5, $urandom(), $urandom(), 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_IDENTITY, 0, 0, 0, 0, 0), 0, '0});
        // Staging extremes, then compose; negative w in the perspective row.
        rows.push_back('{make_req(FUNC_WR_STG, 0, MAXV, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_WR_STG, 5, MINV, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_WR_STG, 10, ONE_Q, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_WR_STG, 14, -ONE_Q, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_WR_STG, 15, 32'sh0000_8000, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_COMPOSE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_XFORM, 0, 0, 32'sh0003_0000, -32'sh0001_8000,
                                  32'sh0001_0000), 0, '0});
        rows.push_back('{make_req(FUNC_XFORM, 0, 0, MAXV, MAXV, MINV), 0, '0});
        rows.push_back('{make_req(FUNC_COMPOSE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(FUNC_XFORM, 0, 0, 32'shffff_ffff, 1, MINV), 0, '0});
        rows.push_back('{make_req(FUNC_IDENTITY, 0, 0, 0, 0, 0), 0, '0});

        foreach (rows[i]) begin
            send_request(rows[i].req);
            // Typed-in expectations must agree with what the predictor queued.
            if (rows[i].has_exp && pending_points[$] !== rows[i].expv) begin
                $display("%0t: row %0d expected %h actual %h", $time, i,
                         rows[i].expv, pending_points[$]);
                errors++;
            end
        end

        // Random part: a random mix of all request kinds, with transforms the most common.
        for (int n = 0; n < 1650; n++) begin
            if (n > 1450) idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0: begin rq = make_req(FUNC_IDENTITY, 4'($urandom()), $urandom(), $urandom(),
                                       $urandom(), $urandom()); end
                1: begin rq = make_req(FUNC_COMPOSE, 4'($urandom()), $urandom(), $urandom(),
                                       $urandom(), $urandom()); end
                2: begin rq = make_req(FUNC_WR_STG, 4'($urandom()), rand_entry(), $urandom(),
                                       $urandom(), $urandom()); end
                3, 4: begin
                    idx = 4'($urandom_range(0, 15));
                    rq = make_req(FUNC_WR_CUR, idx, rand_entry(), $urandom(),
                                  $urandom(), $urandom());
                end
                5: begin rq = make_req(3'($urandom_range(5, 7)), 4'($urandom()), $urandom(),
                                       $urandom(), $urandom(), $urandom()); end
                default: begin rq = make_req(FUNC_XFORM, 4'($urandom()), $urandom(),
                                             rand_coord(), rand_coord(), rand_coord()); end
            endcase
            send_request(rq);
        end
        s_valid <= 1'b0;

        // Drain, then allow the core's longest request time to pass.
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: allows several times what about 1700 requests at their longest
    // request time plus their random stalls need.
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
